// File: rtl/core/hkm_pkg.sv
// Package: constants, types and helpers for the heap k-way merge block.
`timescale 1ns / 1ps
package hkm_pkg;

    localparam int MAX_LISTS = 16;
    localparam int KEY_W     = 31;
    localparam int SRC_W     = 4;
    localparam int CNT_W     = 5;
    localparam int LEVELS    = 5;
    localparam int LVL_W     = 3;
    localparam int SLOTS     = 8;
    localparam int LPOS_W    = 3;
    localparam int GIDX_W    = 6;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [KEY_W-1:0]  END_KEY       = {KEY_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_NUM_LISTS = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_DEDUP     = 3'd4;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_BUILD,
        ST_BWAIT,
        ST_RWAIT,
        ST_EMIT
    } hkm_state_t;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_MERGING,
        PH_DONE
    } hkm_phase_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SRC_W-1:0] src;
    } hkm_entry_t;

    typedef struct packed {
        logic              en;
        logic [LPOS_W-1:0] lpos;
        hkm_entry_t        ent;
    } hkm_tok_t;

    typedef struct packed {
        logic              en;
        logic [LPOS_W-1:0] lpos;
        logic              key_own;
        logic [KEY_W-1:0]  key;
    } hkm_start_t;

    typedef struct packed {
        logic              en;
        logic [LPOS_W-1:0] lpos;
        hkm_entry_t        ent;
    } hkm_wr_t;

    typedef struct packed {
        logic       lok;
        logic       rok;
        hkm_entry_t l;
        hkm_entry_t r;
    } hkm_view_t;

    // heap level of a global index: floor(log2(idx+1))
    function automatic logic [LVL_W-1:0] level_of(input logic [SRC_W-1:0] idx);
        logic [CNT_W-1:0] p;
        logic [LVL_W-1:0] lv;
        p  = {1'b0, idx} + CNT_W'(1);
        lv = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (p[b])
            begin
                lv = LVL_W'(b);
            end
        end
        return lv;
    endfunction

    // position of a global index inside its level
    function automatic logic [LPOS_W-1:0] local_of(input logic [SRC_W-1:0] idx);
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] base;
        p    = {1'b0, idx} + CNT_W'(1);
        base = CNT_W'(1) << level_of(idx);
        return LPOS_W'(p - base);
    endfunction

endpackage

// File: rtl/core/hkm_if.sv
// Handshake channel interfaces for merge input heads and merged results.
`timescale 1ns / 1ps
interface hkm_in_if;
    import hkm_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] value;
    logic             list_ended;

    modport source (output valid, output value, output list_ended, input ready);
    modport sink   (input valid, input value, input list_ended, output ready);
endinterface

interface hkm_out_if;
    import hkm_pkg::*;
    logic             valid;
    logic             ready;
    logic             has_value;
    logic [KEY_W-1:0] out_value;
    logic [SRC_W-1:0] next_list;
    logic             done_res;

    modport source (output valid, output has_value, output out_value,
                    output next_list, output done_res, input ready);
    modport sink   (input valid, input has_value, input out_value,
                    input next_list, input done_res, output ready);
endinterface

// File: rtl/core/hkm_cell.sv
// One heap level: holds its entries and moves the sift token one level per cycle.
`timescale 1ns / 1ps
module hkm_cell
    import hkm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LVL_W-1:0]  lvl,
    input  logic [CNT_W-1:0]  n_act,
    input  hkm_wr_t           wr,
    input  hkm_start_t        start,
    input  hkm_tok_t          tok_in,
    input  logic [LPOS_W-1:0] qry_in,
    input  hkm_view_t         view_in,
    output hkm_tok_t          tok_out,
    output logic [LPOS_W-1:0] qry_out,
    output hkm_view_t         view_out,
    output hkm_entry_t        root,
    output logic              busy
);

    hkm_entry_t       slot_reg [SLOTS];
    hkm_tok_t         tok_reg;
    hkm_tok_t         tok_next;
    logic [GIDX_W-1:0] base;
    logic [CNT_W-1:0] ql;
    logic [CNT_W-1:0] qr;
    logic [GIDX_W-1:0] gl;
    logic [GIDX_W-1:0] gr;
    logic             take_l;
    logic             take_r;
    logic [KEY_W-1:0] cmp_key;
    hkm_entry_t       wb_ent;

    assign base = (GIDX_W'(1) << lvl) - GIDX_W'(1);
    assign ql   = {1'b0, qry_in, 1'b0};
    assign qr   = ql | CNT_W'(1);
    assign gl   = base + GIDX_W'(ql);
    assign gr   = base + GIDX_W'(qr);

    // children of the token one level up
    always_comb
    begin
        view_out.lok = (ql < CNT_W'(SLOTS)) && (gl < GIDX_W'(n_act));
        view_out.rok = (qr < CNT_W'(SLOTS)) && (gr < GIDX_W'(n_act));
        view_out.l   = slot_reg[ql[LPOS_W-1:0]];
        view_out.r   = slot_reg[qr[LPOS_W-1:0]];
    end

    // left child wins ties; strictly smaller to move up
    always_comb
    begin
        take_l  = view_in.lok && (view_in.l.key < tok_reg.ent.key);
        cmp_key = take_l ? view_in.l.key : tok_reg.ent.key;
        take_r  = view_in.rok && (view_in.r.key < cmp_key);
        if (take_r)
        begin
            wb_ent = view_in.r;
        end
        else if (take_l)
        begin
            wb_ent = view_in.l;
        end
        else
        begin
            wb_ent = tok_reg.ent;
        end
        tok_out.en   = tok_reg.en && (take_l || take_r);
        tok_out.lpos = LPOS_W'({tok_reg.lpos, take_r});
        tok_out.ent  = tok_reg.ent;
    end

    always_comb
    begin
        tok_next = '0;
        if (start.en)
        begin
            tok_next.en      = 1'b1;
            tok_next.lpos    = start.lpos;
            tok_next.ent.src = slot_reg[start.lpos].src;
            tok_next.ent.key = start.key_own ? slot_reg[start.lpos].key : start.key;
        end
        else if (tok_in.en)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_reg[wr.lpos] <= wr.ent;
        end
        else if (tok_reg.en)
        begin
            slot_reg[tok_reg.lpos] <= wb_ent;
        end
    end

    assign qry_out = tok_reg.lpos;
    assign root    = slot_reg[0];
    assign busy    = tok_reg.en;

endmodule

// File: rtl/core/heap_kway_merge_union.sv
// Top level: k-way sorted-list merge through a min-heap built from level cells.
// Usage:
//   in_ch carries one beat per list head: value and list_ended (ended lists
//   count as the maximum key). A load is num_lists beats, lists in order;
//   after the last head the heap is built bottom-up and the first minimum
//   is returned. Each later beat must feed the list named by the previous
//   result's next_list. A result with done_res set ends the merge; the next
//   beat starts a new load.
//   out_ch carries one result beat per merge beat and per completed load
//   (load beats before the last head return nothing). has_value low means a
//   duplicate suppressed by dedup_enable, or a done result.
//   Sifting moves one heap level per cycle through five level cells; only one
//   merge beat is in flight at a time. A load end sifts each internal node
//   in turn, from the last one down to the root (up to 8 nodes), each node
//   sinking as far as it must, then the first result is emitted.
//   Reset clears control state and the registers to num_lists 1, dedup on;
//   heap contents are undefined until loaded. A stalled receiver holds the
//   result register; beats are still taken until the next result is ready.
//   Config via APB: num_lists at 0x0, dedup_enable at 0x4; write while idle.
`timescale 1ns / 1ps
module heap_kway_merge_union
    import hkm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    hkm_in_if.sink            in_ch,
    hkm_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [CNT_W-1:0] num_lists_reg;
    logic             dedup_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lists_reg <= CNT_W'(1);
            dedup_reg     <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_NUM_LISTS: num_lists_reg <= pwdata[CNT_W-1:0];
                ADDR_DEDUP:     dedup_reg     <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_NUM_LISTS: prdata = DATA_W'(num_lists_reg);
            ADDR_DEDUP:     prdata = DATA_W'(dedup_reg);
            default:        prdata = '0;
        endcase
    end

    // control state
    hkm_state_t       state_reg, state_next;
    hkm_phase_t       phase_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] active_reg;
    logic [SRC_W-1:0] build_reg;
    logic [KEY_W-1:0] last_reg;
    logic             have_reg;

    logic             out_valid_reg;
    logic             out_has_reg;
    logic [KEY_W-1:0] out_value_reg;
    logic [SRC_W-1:0] out_next_reg;
    logic             out_done_reg;

    logic             in_fire;
    logic             load_mode;
    logic             new_load;
    logic [KEY_W-1:0] key_in;
    logic [CNT_W-1:0] n_clamp;
    logic [CNT_W-1:0] n_load;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_next;
    logic             last_head;
    logic             any_busy;
    logic             emit_fire;
    logic             root_end;
    logic             show;

    logic [LEVELS-1:0] busy;
    hkm_wr_t           wr_cmd;
    hkm_start_t        start_cmd;
    logic [LVL_W-1:0]  wr_lvl;
    logic [LVL_W-1:0]  start_lvl;

    hkm_tok_t          tok_link  [LEVELS+1];
    hkm_view_t         view_link [LEVELS+1];
    logic [LPOS_W-1:0] qry_link  [LEVELS+1];
    hkm_entry_t        root_link [LEVELS];

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign key_in    = in_ch.list_ended ? END_KEY : in_ch.value;
    assign load_mode = (phase_reg != PH_MERGING);
    assign new_load  = (phase_reg == PH_DONE) || (count_reg == '0);
    assign any_busy  = |busy;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        if (num_lists_reg == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (num_lists_reg > CNT_W'(MAX_LISTS))
        begin
            n_clamp = CNT_W'(MAX_LISTS);
        end
        else
        begin
            n_clamp = num_lists_reg;
        end
        n_load    = new_load ? n_clamp : active_reg;
        cnt       = (new_load || count_reg >= active_reg) ? '0 : count_reg;
        cnt_next  = cnt + CNT_W'(1);
        last_head = (cnt_next >= n_load);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (in_fire)
                begin
                    if (!load_mode)
                    begin
                        state_next = ST_RWAIT;
                    end
                    else if (last_head)
                    begin
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_BUILD: state_next = ST_BWAIT;
            ST_BWAIT:
            begin
                if (!any_busy)
                begin
                    state_next = (build_reg == '0) ? ST_EMIT : ST_BUILD;
                end
            end
            ST_RWAIT:
            begin
                if (!any_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // commands to the cells
    always_comb
    begin
        in_ch.ready    = (state_reg == ST_ACCEPT);
        wr_cmd.en      = in_fire && load_mode;
        wr_cmd.lpos    = local_of(cnt[SRC_W-1:0]);
        wr_cmd.ent.key = key_in;
        wr_cmd.ent.src = cnt[SRC_W-1:0];
        wr_lvl         = level_of(cnt[SRC_W-1:0]);
        start_cmd      = '0;
        start_lvl      = '0;
        if (state_reg == ST_BUILD)
        begin
            start_cmd.en      = 1'b1;
            start_cmd.lpos    = local_of(build_reg);
            start_cmd.key_own = 1'b1;
            start_lvl         = level_of(build_reg);
        end
        else if (in_fire && !load_mode)
        begin
            start_cmd.en  = 1'b1;
            start_cmd.key = key_in;
        end
    end

    assign tok_link[0]       = '0;
    assign qry_link[0]       = '0;
    assign view_link[LEVELS] = '0;

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        hkm_wr_t    wr_i;
        hkm_start_t st_i;

        always_comb
        begin
            wr_i    = wr_cmd;
            wr_i.en = wr_cmd.en && (wr_lvl == LVL_W'(i));
            st_i    = start_cmd;
            st_i.en = start_cmd.en && (start_lvl == LVL_W'(i));
        end

        hkm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .lvl      (LVL_W'(i)),
            .n_act    (active_reg),
            .wr       (wr_i),
            .start    (st_i),
            .tok_in   (tok_link[i]),
            .qry_in   (qry_link[i]),
            .view_in  (view_link[i+1]),
            .tok_out  (tok_link[i+1]),
            .qry_out  (qry_link[i+1]),
            .view_out (view_link[i]),
            .root     (root_link[i]),
            .busy     (busy[i])
        );
    end

    assign root_end = (root_link[0].key == END_KEY);
    assign show     = !(dedup_reg && have_reg && (root_link[0].key == last_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            phase_reg     <= PH_LOADING;
            count_reg     <= '0;
            active_reg    <= CNT_W'(1);
            build_reg     <= '0;
            last_reg      <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire && load_mode)
            begin
                if (new_load)
                begin
                    active_reg <= n_clamp;
                    have_reg   <= 1'b0;
                    last_reg   <= '0;
                end
                if (last_head)
                begin
                    count_reg <= '0;
                    phase_reg <= PH_MERGING;
                    build_reg <= SRC_W'((n_load - CNT_W'(1)) >> 1);
                end
                else
                begin
                    count_reg <= cnt_next;
                    phase_reg <= PH_LOADING;
                end
            end
            if (state_reg == ST_BWAIT && !any_busy && build_reg != '0)
            begin
                build_reg <= build_reg - SRC_W'(1);
            end
            if (emit_fire)
            begin
                if (root_end)
                begin
                    phase_reg <= PH_DONE;
                end
                else if (show)
                begin
                    last_reg <= root_link[0].key;
                    have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_has_reg   <= !root_end && show;
            out_value_reg <= root_end ? '0 : root_link[0].key;
            out_next_reg  <= root_end ? '0 : root_link[0].src;
            out_done_reg  <= root_end;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.has_value = out_has_reg;
    assign out_ch.out_value = out_value_reg;
    assign out_ch.next_list = out_next_reg;
    assign out_ch.done_res  = out_done_reg;

    // only one level holds the sift token at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(busy))
        else $error("more than one cell holds a sift token");

    // a sift is started only when the chain is quiet
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start_cmd.en |-> !any_busy)
        else $error("sift started while chain busy");

    // a done result never carries a value
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && root_end |=> out_ch.done_res && !out_ch.has_value)
        else $error("done result carries a value");

endmodule

// File: verif/heap_kway_merge_union_test.sv
// Testbench for heap_kway_merge_union: directed table then sorted-list random merges.
`timescale 1ns / 1ps
module heap_kway_merge_union_test;
    import hkm_pkg::*;

    // One merged-output beat as the block should return it.
    typedef struct packed {
        logic             has_value;
        logic [KEY_W-1:0] out_value;
        logic [SRC_W-1:0] next_list;
        logic             done_res;
    } merge_res_t;

    // Directed row: optional register writes (-1 keeps), the input beat, and
    // a hand-typed result where one is plainly known (otherwise predicted).
    typedef struct {
        int               set_n;
        int               set_dd;
        logic [KEY_W-1:0] value;
        bit               ended;
        bit               typed;
        merge_res_t       res;
    } dir_row_t;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    TAIL_CYCLES = 24;
    localparam int    RAND_BEATS  = 200;   // per idling phase, three phases
    localparam logic [KEY_W-1:0] TOP_KEY = END_KEY - KEY_W'(1);

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    hkm_in_if  in_ch();
    hkm_out_if out_ch();

    heap_kway_merge_union i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: heap of list heads plus merge bookkeeping
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] heap_key [MAX_LISTS];
    logic [SRC_W-1:0] heap_src [MAX_LISTS];
    int               loaded;          // heads taken in the current load
    int               lists_live;      // list count latched at load start
    logic [KEY_W-1:0] prev_out;
    bit               prev_valid;
    hkm_phase_t       phase;
    logic [SRC_W-1:0] want_list;       // list the block asks for next
    logic [CNT_W-1:0] lists_reg;       // register copies
    bit               dedup_reg;

    // stimulus-side memory of each list's last element, keeps lists sorted
    logic [KEY_W-1:0] list_tail [MAX_LISTS];

    merge_res_t pending_res [$];
    int         err_count;
    int         send_idle;
    int         recv_idle;
    int         cycles;

    function automatic void heap_sift(input int pos);
        int               l;
        int               r;
        int               best;
        logic [KEY_W-1:0] tk;
        logic [SRC_W-1:0] ts;
        while (pos < lists_live)
        begin
            l    = 2 * pos + 1;
            r    = 2 * pos + 2;
            best = pos;
            // left wins ties; strictly smaller to move up
            if (l < lists_live && heap_key[l] < heap_key[pos])
                best = l;
            if (r < lists_live && heap_key[r] < heap_key[best])
                best = r;
            if (best == pos)
                break;
            tk = heap_key[pos]; heap_key[pos] = heap_key[best]; heap_key[best] = tk;
            ts = heap_src[pos]; heap_src[pos] = heap_src[best]; heap_src[best] = ts;
            pos = best;
        end
    endfunction

    function automatic merge_res_t root_result();
        merge_res_t res;
        bit         show;
        res = '0;
        if (heap_key[0] == END_KEY)
        begin
            res.done_res = 1'b1;
            phase        = PH_DONE;
            want_list    = '0;
        end
        else
        begin
            // first value of a merge always shows
            show = !(dedup_reg && prev_valid && heap_key[0] == prev_out);
            if (show)
            begin
                prev_out   = heap_key[0];
                prev_valid = 1'b1;
            end
            res.has_value = show;
            res.out_value = heap_key[0];
            res.next_list = heap_src[0];
            want_list     = heap_src[0];
        end
        return res;
    endfunction

    function automatic bit merge_step(input logic [KEY_W-1:0] value, input bit ended,
                                      output merge_res_t res);
        logic [KEY_W-1:0] key;
        int               n;
        key = ended ? END_KEY : value;   // all ones doubles as the end key
        res = '0;
        if (phase == PH_DONE)
        begin
            phase  = PH_LOADING;
            loaded = 0;
        end
        if (phase == PH_LOADING)
        begin
            if (loaded == 0)
            begin
                n = int'(lists_reg);
                if (n < 1)
                    n = 1;
                if (n > MAX_LISTS)
                    n = MAX_LISTS;
                lists_live = n;
                prev_valid = 1'b0;
                prev_out   = '0;
            end
            heap_key[loaded] = key;
            heap_src[loaded] = SRC_W'(loaded);
            loaded++;
            if (loaded < lists_live)
                return 1'b0;
            for (int i = (lists_live - 1) / 2; i >= 0; i--)
                heap_sift(i);
            loaded = 0;
            phase  = PH_MERGING;
            res    = root_result();
            return 1'b1;
        end
        heap_key[0] = key;
        heap_sift(0);
        res = root_result();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("heap_kway_merge_union_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check each accepted beat, then pick next ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        merge_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result beat with nothing expected");
                err_count++;
            end
            else
            begin
                want = pending_res.pop_front();
                if (out_ch.has_value !== want.has_value)
                begin
                    $error("has_value: expected %0d, got %0d", want.has_value,
                           out_ch.has_value);
                    err_count++;
                end
                if (out_ch.out_value !== want.out_value)
                begin
                    $error("out_value: expected %h, got %h", want.out_value,
                           out_ch.out_value);
                    err_count++;
                end
                if (out_ch.next_list !== want.next_list)
                begin
                    $error("next_list: expected %0d, got %0d", want.next_list,
                           out_ch.next_list);
                    err_count++;
                end
                if (out_ch.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", want.done_res,
                           out_ch.done_res);
                    err_count++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);   // register takes the write on this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_NUM_LISTS)
            lists_reg = data[CNT_W-1:0];
        else if (addr == ADDR_DEDUP)
            dedup_reg = data[0];
        @(posedge clk);   // bus idle before the next transfer
    endtask

    // Pause the sender until every expected result is back, then let the
    // block settle (a load head can still be in flight with no result).
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Send one beat; returns once accepted. typed rows supply their result.
    task automatic send_beat(input logic [KEY_W-1:0] value, input bit ended,
                             input bit typed, input merge_res_t typed_res);
        merge_res_t res;
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= value;
        in_ch.list_ended <= ended;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (merge_step(value, ended, res))
            pending_res.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [KEY_W-1:0] head_value();
        case ($urandom_range(3))
            0:       return KEY_W'($urandom);
            1:       return KEY_W'($urandom_range(20));
            2:       return TOP_KEY - KEY_W'($urandom_range(14));
            default: return KEY_W'($urandom_range(1000));
        endcase
    endfunction

    // Mostly well-formed: heads in load order, then the list the block asked
    // for, ascending; a small share of free noise beats.
    task automatic rand_beat();
        logic [KEY_W-1:0] value;
        bit               ended;
        int               list;
        logic [31:0]      sum;
        if ($urandom_range(99) < 8)
        begin
            value = KEY_W'($urandom);
            ended = ($urandom_range(4) == 0);
        end
        else if (phase != PH_MERGING)
        begin
            list  = (phase == PH_DONE) ? 0 : loaded;
            value = head_value();
            ended = ($urandom_range(99) < 8);
            list_tail[list] = value;
        end
        else
        begin
            list  = int'(want_list);
            ended = ($urandom_range(99) < 15);
            sum   = 32'(list_tail[list]) +
                    (($urandom_range(9) == 0) ? 32'($urandom_range(100000))
                                              : 32'($urandom_range(2)));
            value = (sum > 32'(TOP_KEY)) ? TOP_KEY : sum[KEY_W-1:0];
            list_tail[list] = value;
        end
        send_beat(value, ended, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    dir_row_t dir_rows [] = '{
        // after reset: one list, dedup on; first value always shows
        '{-1, -1, 31'd0,   1'b0, 1'b1, '{1'b1, 31'd0, 4'd0, 1'b0}},
        // duplicate suppressed, value still reported
        '{-1, -1, 31'd0,   1'b0, 1'b1, '{1'b0, 31'd0, 4'd0, 1'b0}},
        '{-1, -1, TOP_KEY, 1'b0, 1'b1, '{1'b1, TOP_KEY, 4'd0, 1'b0}},
        '{-1, -1, 31'd0,   1'b1, 1'b1, '{1'b0, 31'd0, 4'd0, 1'b1}},
        // all-ones head behaves as an ended list
        '{-1, -1, END_KEY, 1'b0, 1'b1, '{1'b0, 31'd0, 4'd0, 1'b1}},
        '{-1, -1, 31'd5,   1'b0, 1'b1, '{1'b1, 31'd5, 4'd0, 1'b0}},
        '{-1, -1, 31'd9,   1'b1, 1'b1, '{1'b0, 31'd0, 4'd0, 1'b1}},
        // four lists, dedup off; tie between lists 1 and 2, list 3 ended at load
        '{4,  0,  31'd7,   1'b0, 1'b0, '0},
        '{-1, -1, 31'd3,   1'b0, 1'b0, '0},
        '{-1, -1, 31'd3,   1'b0, 1'b0, '0},
        '{-1, -1, 31'd0,   1'b1, 1'b0, '0},
        '{-1, -1, 31'd3,   1'b0, 1'b0, '0},
        // count written mid-merge only bites at next load; dedup bites now
        '{0,  1,  31'd3,   1'b0, 1'b0, '0},
        '{-1, -1, 31'd0,   1'b1, 1'b0, '0},
        '{-1, -1, 31'd0,   1'b1, 1'b0, '0},
        '{-1, -1, 31'd0,   1'b1, 1'b0, '0},
        // count 0 is taken as one list
        '{-1, -1, 31'd11,  1'b0, 1'b1, '{1'b1, 31'd11, 4'd0, 1'b0}},
        '{-1, -1, 31'd0,   1'b1, 1'b1, '{1'b0, 31'd0, 4'd0, 1'b1}},
        // count above the maximum clamps to sixteen; load runs on in random part
        '{31, -1, 31'd100, 1'b0, 1'b0, '0},
        '{-1, -1, 31'd100, 1'b0, 1'b0, '0},
        '{-1, -1, 31'd2,   1'b0, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.list_ended = 1'b0;
        out_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        err_count        = 0;
        cycles           = 0;
        send_idle        = 35;
        recv_idle        = 65;
        lists_reg        = CNT_W'(1);
        dedup_reg        = 1'b1;
        lists_live       = 1;
        loaded           = 0;
        prev_out         = '0;
        prev_valid       = 1'b0;
        phase            = PH_LOADING;
        want_list        = '0;
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            heap_key[i]  = '0;
            heap_src[i]  = '0;
            list_tail[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].set_n >= 0 || dir_rows[k].set_dd >= 0)
            begin
                drain();
                if (dir_rows[k].set_n >= 0)
                    reg_write(ADDR_NUM_LISTS, DATA_W'(dir_rows[k].set_n));
                if (dir_rows[k].set_dd >= 0)
                    reg_write(ADDR_DEDUP, DATA_W'(dir_rows[k].set_dd));
            end
            send_beat(dir_rows[k].value, dir_rows[k].ended, dir_rows[k].typed,
                      dir_rows[k].res);
        end

        // three idling phases, fresh settings before each
        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    send_idle = 35;
                    recv_idle = 65;
                    reg_write(ADDR_NUM_LISTS, DATA_W'($urandom_range(2, 5)));
                    reg_write(ADDR_DEDUP, 32'd1);
                end
                1:
                begin
                    send_idle = 65;
                    recv_idle = 35;
                    reg_write(ADDR_NUM_LISTS, 32'd16);
                    reg_write(ADDR_DEDUP, 32'd0);
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    reg_write(ADDR_NUM_LISTS, DATA_W'($urandom_range(1, 16)));
                    reg_write(ADDR_DEDUP, DATA_W'($urandom_range(1)));
                end
            endcase
            for (int b = 0; b < RAND_BEATS; b++)
            begin
                // mid-phase: sender waits for the block to empty out, and
                // the settings move (small list counts, one list too)
                if (b == RAND_BEATS / 2)
                begin
                    drain();
                    reg_write(ADDR_NUM_LISTS,
                              DATA_W'(($urandom_range(3) == 0) ? 1 : $urandom_range(2, 6)));
                    reg_write(ADDR_DEDUP, DATA_W'($urandom_range(1)));
                end
                rand_beat();
            end
        end

        drain();
        if (err_count == 0)
            $display("heap_kway_merge_union_test: clean");
        else
            $display("heap_kway_merge_union_test: errors");
        $finish;
    end

endmodule
